FILE: src/hidkb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidkb_pkg: shared types and constants for the keyboard report builder
// Report layout, key event modes and the ASCII to usage lookup.
// ----------------------------------------------------------------------------
package hidkb_pkg;

  localparam int NUM_SLOTS = 6;

  localparam logic [7:0] RAW_BASE    = 8'd136;
  localparam logic [7:0] MOD_BASE    = 8'd128;
  localparam logic [7:0] LEFT_SHIFT  = 8'h02;
  localparam logic [7:0] USAGE_MASK  = 8'h7F;
  localparam logic [7:0] NEEDS_SHIFT = 8'h80;

  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_REL_ALL = 2'd2,
    MODE_WRITE   = 2'd3
  } mode_t;

  typedef logic [NUM_SLOTS-1:0][7:0] slot_arr_t;

  typedef struct packed {
    logic [7:0] mods;
    slot_arr_t  slots;
  } report_t;

  // bit 7 set: character needs left shift
  localparam logic [7:0] CHAR_USAGE [0:127] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
    8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
    8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
    8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
    8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
    8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
    8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
    8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
    8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
    8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
    8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
    8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
  };

endpackage

FILE: src/hidkb_key_op.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidkb_key_op: single key press or release on the report
// Decodes the key code and returns the updated report and the status.
// ----------------------------------------------------------------------------
module hidkb_key_op import hidkb_pkg::*; (
  input  report_t    cur,
  input  logic [7:0] key_code,
  input  logic       press,
  output report_t    nxt,
  output logic       ok
);

  logic [7:0] tab;
  logic [7:0] usage;
  logic [7:0] mbit;
  logic [7:0] mod_upd;
  logic       mapped;
  logic       present;
  logic       placed;

  assign tab = CHAR_USAGE[key_code[6:0]];

  always_comb begin
    mod_upd = cur.mods;
    usage   = '0;
    mapped  = 1'b1;
    mbit    = 8'd1 << key_code[2:0];
    if (key_code >= RAW_BASE) begin
      usage = key_code - RAW_BASE;
    end else if (key_code >= MOD_BASE) begin
      mod_upd = press ? (cur.mods | mbit) : (cur.mods & ~mbit);
    end else if (tab == 8'd0) begin
      mapped = 1'b0;
    end else begin
      usage = tab & USAGE_MASK;
      if ((tab & NEEDS_SHIFT) != 8'd0) begin
        mod_upd = press ? (cur.mods | LEFT_SHIFT) : (cur.mods & ~LEFT_SHIFT);
      end
    end
  end

  always_comb begin
    present = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (cur.slots[i] == usage) present = 1'b1;
    end
  end

  always_comb begin
    nxt    = cur;
    ok     = 1'b0;
    placed = 1'b0;
    if (mapped) begin
      nxt.mods = mod_upd;
      if (press) begin
        if (present) begin
          ok = 1'b1;
        end else begin
          // first free slot takes the usage
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!placed && cur.slots[i] == 8'd0) begin
              nxt.slots[i] = usage;
              placed       = 1'b1;
            end
          end
          ok = placed;
        end
      end else begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (usage != 8'd0 && cur.slots[i] == usage) nxt.slots[i] = 8'd0;
        end
        ok = 1'b1;
      end
    end
  end

endmodule

FILE: src/hid_keyboard_report_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder: boot keyboard report, six key rollover
// Holds the modifier byte and six key slots and applies key events to them.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its result appears with
// out_valid after the item register and then the report register, and lasts
// one cycle; the receiver cannot stall it. Press, release and release-all items
// give one result, and while busy is low a new item may be taken every cycle.
// A write item gives two results on consecutive cycles (press, then release)
// and holds busy high for one cycle, since the single key update stage between
// the item register and the report register handles one press or release per
// cycle. The report fields always show the report after the operation, also on
// status-only results.
module hid_keyboard_report_builder import hidkb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_key_code,
  output logic       out_valid,
  output logic       out_report_sent,
  output logic       out_success,
  output logic [7:0] out_modifier_bits,
  output logic [7:0] out_slot_one,
  output logic [7:0] out_slot_two,
  output logic [7:0] out_slot_three,
  output logic [7:0] out_slot_four,
  output logic [7:0] out_slot_five,
  output logic [7:0] out_slot_six,
  output logic       out_final_result
);

  logic       in_vld_r,  in_vld_nxt;
  mode_t      mode_r;
  logic [7:0] code_r;
  logic       phase_r,   phase_nxt;
  report_t    rpt_r,     rpt_nxt;
  logic       out_vld_r;
  logic       ok_r,      ok_nxt;
  logic       final_r,   final_nxt;

  report_t    op_rpt;
  logic       op_ok;
  logic       op_press;
  logic       accept;

  assign busy   = in_vld_r && mode_r == MODE_WRITE && !phase_r;
  assign accept = start && !busy;

  assign op_press = (mode_r == MODE_PRESS) || (mode_r == MODE_WRITE && !phase_r);

  hidkb_key_op u_key_op (
    .cur      (rpt_r),
    .key_code (code_r),
    .press    (op_press),
    .nxt      (op_rpt),
    .ok       (op_ok)
  );

  always_comb begin
    in_vld_nxt = accept || busy;
    phase_nxt  = busy;
    rpt_nxt    = rpt_r;
    ok_nxt     = ok_r;
    final_nxt  = final_r;
    if (in_vld_r) begin
      final_nxt = !busy;
      case (mode_r)
        MODE_REL_ALL: begin
          rpt_nxt = '0;
          ok_nxt  = 1'b1;
        end
        MODE_PRESS, MODE_RELEASE, MODE_WRITE: begin
          rpt_nxt = op_rpt;
          ok_nxt  = op_ok;
        end
        default: begin
          rpt_nxt = rpt_r;
          ok_nxt  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      phase_r   <= 1'b0;
      rpt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      phase_r   <= phase_nxt;
      rpt_r     <= rpt_nxt;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode_t'(in_mode);
      code_r <= in_key_code;
    end
    ok_r    <= ok_nxt;
    final_r <= final_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_report_sent   = ok_r;
  assign out_success       = ok_r;
  assign out_final_result  = final_r;
  assign out_modifier_bits = rpt_r.mods;
  assign out_slot_one      = rpt_r.slots[0];
  assign out_slot_two      = rpt_r.slots[1];
  assign out_slot_three    = rpt_r.slots[2];
  assign out_slot_four     = rpt_r.slots[3];
  assign out_slot_five     = rpt_r.slots[4];
  assign out_slot_six      = rpt_r.slots[5];

`ifndef NO_ASSERTIONS
  a_write_first: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !out_final_result)
    else $error("write press result missing or marked final");

  a_write_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_result |=> out_valid && out_final_result)
    else $error("write release result did not follow");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> in_vld_r && phase_r)
    else $error("write item lost its second phase");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy && out_modifier_bits == 8'd0)
    else $error("state not cleared by reset");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: key event checks for the boot keyboard report builder
// Key events go in through the start/busy handshake. A scoreboard keeps its
// own copy of the modifier byte and six key slots and predicts every report.
// Each report strobe is compared field by field with the oldest prediction.
// A directed run over the corner cases comes first, then random typing runs.
// ----------------------------------------------------------------------------
module testbench;
  import hidkb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 650;
  localparam int HISTORY_SIZE = 8;

  typedef struct packed {
    logic       sent;
    logic       ok;
    logic [7:0] mods;
    slot_arr_t  slots;
    logic       last;
  } key_report_t;

  class key_report_scoreboard;
    logic [7:0]  mods;
    slot_arr_t   slots;
    key_report_t pending_reports[$];
    int          errors;

    function new();
      clear_report();
      errors = 0;
    endfunction

    function void clear_report();
      mods  = '0;
      slots = '0;
    endfunction

    function logic [7:0] key_usage(input logic [7:0] code, input bit pressing);
      logic [7:0] u;
      if (code >= RAW_BASE) begin
        u = code - RAW_BASE;
      end else if (code >= MOD_BASE) begin
        mods[code[2:0]] = pressing;
        u = '0;
      end else begin
        u = CHAR_USAGE[code[6:0]];
        if ((u & NEEDS_SHIFT) != 0) begin
          mods = pressing ? (mods | LEFT_SHIFT) : (mods & ~LEFT_SHIFT);
          u = u & USAGE_MASK;
        end
      end
      return u;
    endfunction

    function bit press_key(input logic [7:0] code);
      logic [7:0] u;
      if (code < MOD_BASE && CHAR_USAGE[code[6:0]] == 0) return 1'b0;
      u = key_usage(code, 1'b1);
      for (int i = 0; i < NUM_SLOTS; i++)
        if (slots[i] == u) return 1'b1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slots[i] == 0) begin
          slots[i] = u;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function bit release_key(input logic [7:0] code);
      logic [7:0] u;
      if (code < MOD_BASE && CHAR_USAGE[code[6:0]] == 0) return 1'b0;
      u = key_usage(code, 1'b0);
      for (int i = 0; i < NUM_SLOTS; i++)
        if (u != 0 && slots[i] == u) slots[i] = '0;
      return 1'b1;
    endfunction

    function void push_report(input bit ok, input bit last);
      key_report_t r;
      r.sent  = ok;
      r.ok    = ok;
      r.mods  = mods;
      r.slots = slots;
      r.last  = last;
      pending_reports.push_back(r);
    endfunction

    function void note_item(input mode_t m, input logic [7:0] code);
      bit ok;
      case (m)
        MODE_PRESS: begin
          ok = press_key(code);
          push_report(ok, 1'b1);
        end
        MODE_RELEASE: begin
          ok = release_key(code);
          push_report(ok, 1'b1);
        end
        MODE_REL_ALL: begin
          clear_report();
          push_report(1'b1, 1'b1);
        end
        default: begin
          ok = press_key(code);
          push_report(ok, 1'b0);
          ok = release_key(code);
          push_report(ok, 1'b1);
        end
      endcase
    endfunction

    function void compare(input string name, input logic [7:0] exp_v,
                          input logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_report(input key_report_t act);
      key_report_t exp_r;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got %0h", $time, act);
        errors++;
        return;
      end
      exp_r = pending_reports.pop_front();
      compare("report_sent", {7'd0, exp_r.sent}, {7'd0, act.sent});
      compare("success", {7'd0, exp_r.ok}, {7'd0, act.ok});
      compare("modifier_bits", exp_r.mods, act.mods);
      for (int i = 0; i < NUM_SLOTS; i++)
        compare($sformatf("slot %0d", i + 1), exp_r.slots[i], act.slots[i]);
      compare("final_result", {7'd0, exp_r.last}, {7'd0, act.last});
    endfunction

    function int outstanding();
      return pending_reports.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_mode;
  logic [7:0] in_key_code;
  logic       out_valid;
  logic       out_report_sent;
  logic       out_success;
  logic [7:0] out_modifier_bits;
  logic [7:0] out_slot_one;
  logic [7:0] out_slot_two;
  logic [7:0] out_slot_three;
  logic [7:0] out_slot_four;
  logic [7:0] out_slot_five;
  logic [7:0] out_slot_six;
  logic       out_final_result;

  key_report_scoreboard board;
  logic [7:0]           held_codes[$];
  int                   cycle_count = 0;

  hid_keyboard_report_builder DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_key_code       (in_key_code),
    .out_valid         (out_valid),
    .out_report_sent   (out_report_sent),
    .out_success       (out_success),
    .out_modifier_bits (out_modifier_bits),
    .out_slot_one      (out_slot_one),
    .out_slot_two      (out_slot_two),
    .out_slot_three    (out_slot_three),
    .out_slot_four     (out_slot_four),
    .out_slot_five     (out_slot_five),
    .out_slot_six      (out_slot_six),
    .out_final_result  (out_final_result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    key_report_t act;
    if (rst_n && out_valid) begin
      act.sent  = out_report_sent;
      act.ok    = out_success;
      act.mods  = out_modifier_bits;
      act.slots = {out_slot_six, out_slot_five, out_slot_four,
                   out_slot_three, out_slot_two, out_slot_one};
      act.last  = out_final_result;
      board.check_report(act);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input mode_t m, input logic [7:0] code, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    in_mode     <= m;
    in_key_code <= code;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    board.note_item(m, code);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (board.outstanding() > 0) @(negedge clk);
  endtask

  function automatic logic [7:0] random_code();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 8'($urandom_range(8'h7E, 8'h20));
    if (r < 65) return 8'($urandom_range(127, 0));
    if (r < 77) return 8'($urandom_range(135, 128));
    return 8'($urandom_range(255, 136));
  endfunction

  task automatic typing_run(input int n, input int idle_pct);
    mode_t       m;
    logic [7:0]  code;
    int          r;
    for (int k = 0; k < n; k++) begin
      r    = $urandom_range(99);
      code = random_code();
      if (r < 8) begin
        m = MODE_REL_ALL;
        held_codes.delete();
      end else if (r < 40) begin
        m = MODE_PRESS;
      end else if (r < 68) begin
        m = MODE_RELEASE;
        if (held_codes.size() > 0 && $urandom_range(99) < 60)
          code = held_codes[$urandom_range(held_codes.size() - 1)];
      end else begin
        m = MODE_WRITE;
      end
      if (m == MODE_PRESS) begin
        held_codes.push_back(code);
        if (held_codes.size() > HISTORY_SIZE) void'(held_codes.pop_front());
      end
      send_item(m, code, idle_pct);
    end
  endtask

  initial begin
    board       = new();
    rst_n       = 1'b0;
    start       = 1'b0;
    in_mode     = MODE_PRESS;
    in_key_code = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fill all six slots, then overflow, duplicates and zero usage
    send_item(MODE_PRESS,   8'h61, 0);
    send_item(MODE_PRESS,   8'h41, 0);
    send_item(MODE_PRESS,   8'h00, 0);
    send_item(MODE_RELEASE, 8'h7F, 0);
    send_item(MODE_PRESS,   8'h80, 0);
    send_item(MODE_PRESS,   8'h87, 0);
    send_item(MODE_PRESS,   8'h88, 0);
    send_item(MODE_PRESS,   8'hFF, 0);
    send_item(MODE_PRESS,   8'h31, 0);
    send_item(MODE_PRESS,   8'h20, 0);
    send_item(MODE_PRESS,   8'h0A, 0);
    send_item(MODE_PRESS,   8'h09, 0);
    send_item(MODE_PRESS,   8'h62, 0);
    send_item(MODE_PRESS,   8'h81, 0);
    send_item(MODE_PRESS,   8'h88, 0);
    send_item(MODE_PRESS,   8'h61, 0);
    send_item(MODE_RELEASE, 8'h88, 0);
    send_item(MODE_RELEASE, 8'h87, 0);
    send_item(MODE_RELEASE, 8'h41, 0);
    send_item(MODE_WRITE,   8'h7E, 0);
    send_item(MODE_WRITE,   8'h00, 0);
    send_item(MODE_REL_ALL, 8'h00, 0);
    send_item(MODE_WRITE,   8'hFF, 0);
    send_item(MODE_RELEASE, 8'h80, 0);
    send_item(MODE_REL_ALL, 8'hFF, 0);
    wait_drained();

    typing_run(PHASE_ITEMS, 28);
    wait_drained();
    typing_run(PHASE_ITEMS, 83);
    wait_drained();
    typing_run(PHASE_ITEMS, 0);

    wait_drained();
    repeat (8) @(negedge clk);
    if (board.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
